/* src/nor_flash_command_decoder_top_macros.svh */
// Assertion macros shared by the decoder RTL.
// Each macro checks a property on the rising clock edge and is disabled while reset is active.
`ifndef NOR_FLASH_COMMAND_DECODER_TOP_MACROS_SVH
`define NOR_FLASH_COMMAND_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define NFCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("decoder assertion failed");

// Checks that the consequent holds in the clock cycle after the antecedent.
`define NFCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`else

`define NFCD_ASSERT(lbl, clk, rst_n, prop)
`define NFCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/nfcd_pkg.sv */
`default_nettype none

package nfcd_pkg;

  // Default geometry of the flash array.
  localparam int unsigned WORD_ADDR_BITS = 18;
  localparam int unsigned SECTOR_WORDS   = 1024;
  localparam int unsigned BLOCK_WORDS    = 32768;

  // Field and register widths.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Transaction kinds on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MANUF       = 2'd0,
    CFG_DEVICE      = 2'd1,
    CFG_PROG_TICKS  = 2'd2,
    CFG_ERASE_TICKS = 2'd3
  } cfg_idx_e;

  // Configuration reset values.
  localparam logic [DATA_W-1:0] MANUF_RESET       = 16'h0062;
  localparam logic [DATA_W-1:0] DEVICE_RESET      = 16'h0002;
  localparam logic [DATA_W-1:0] PROG_TICKS_RESET  = 16'd16;
  localparam logic [TICK_W-1:0] ERASE_TICKS_RESET = 24'd1000;

  // Unlock addresses.
  localparam logic [11:0] UNLOCK_ADDR1 = 12'h555;
  localparam logic [11:0] UNLOCK_ADDR2 = 12'h2AA;

  // Command bytes.
  localparam logic [CMD_W-1:0] CMD_UNLOCK1         = 8'hAA;
  localparam logic [CMD_W-1:0] CMD_UNLOCK2         = 8'h55;
  localparam logic [CMD_W-1:0] CMD_AUTOSELECT      = 8'h90;
  localparam logic [CMD_W-1:0] CMD_PROGRAM         = 8'hA0;
  localparam logic [CMD_W-1:0] CMD_ERASE_SETUP     = 8'h80;
  localparam logic [CMD_W-1:0] CMD_LOCK_SETUP      = 8'hE0;
  localparam logic [CMD_W-1:0] CMD_CHIP_LOCK_SETUP = 8'hD0;
  localparam logic [CMD_W-1:0] CMD_CHIP_ERASE      = 8'h10;
  localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE    = 8'h30;
  localparam logic [CMD_W-1:0] CMD_BLOCK_ERASE     = 8'h50;
  localparam logic [CMD_W-1:0] CMD_UNLOCK_ALL      = 8'h01;
  localparam logic [CMD_W-1:0] CMD_LOCK            = 8'h00;

  // ID mode word offsets.
  localparam logic [1:0] ID_MANUF      = 2'd0;
  localparam logic [1:0] ID_DEVICE     = 2'd1;
  localparam logic [1:0] ID_BLOCK_LOCK = 2'd2;
  localparam logic [1:0] ID_CHIP_LOCK  = 2'd3;

endpackage

`default_nettype wire

/* src/nfcd_in_if.sv */
`default_nettype none

// Input channel: one bus read, bus write or tick per transaction.
interface nfcd_in_if #(
  parameter int unsigned ADDR_W = nfcd_pkg::WORD_ADDR_BITS
);
  logic                          valid;
  logic                          ready;
  logic [nfcd_pkg::KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]             word_address;
  logic [nfcd_pkg::DATA_W-1:0]   data_word;

  modport source (output valid, kind, word_address, data_word, input ready);
  modport sink   (input valid, kind, word_address, data_word, output ready);
endinterface

`default_nettype wire

/* src/nfcd_out_if.sv */
`default_nettype none

// Result channel: one result per input transaction.
interface nfcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfcd_pkg::DATA_W-1:0] read_data;
  logic                        busy_res;
  logic                        refused;

  modport source (output valid, read_data, busy_res, refused, input ready);
  modport sink   (input valid, read_data, busy_res, refused, output ready);
endinterface

`default_nettype wire

/* src/nfcd_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module nfcd_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/nor_flash_command_decoder_top.sv */
`default_nettype none

`include "nor_flash_command_decoder_top_macros.svh"

// NOR flash command decoder: models a 16-bit NOR flash as seen from its bus. Each input
// transaction is a bus read, a bus write or one time tick, and yields exactly one result.
// The array lives in a single RAM with a registered read. An array read issues the RAM
// read, then registers the result; a word program reads the word, then ANDs and writes it
// back; ID reads, poll reads, other writes and ticks register their result directly. An
// accepted erase walks its range in the RAM write port, one word per cycle: SECTOR_WORDS
// words for a sector, BLOCK_WORDS for a block (at most the array size), 2**WORD_ADDR_BITS
// for the chip. After reset the same walk fills the whole array with FFFF, during which
// no input transaction is taken; configuration writes are taken at any time. SECTOR_WORDS
// and BLOCK_WORDS must be powers of two.
module nor_flash_command_decoder_top #(
  parameter int unsigned WORD_ADDR_BITS = nfcd_pkg::WORD_ADDR_BITS,
  parameter int unsigned SECTOR_WORDS   = nfcd_pkg::SECTOR_WORDS,
  parameter int unsigned BLOCK_WORDS    = nfcd_pkg::BLOCK_WORDS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nfcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nfcd_pkg::CFG_W-1:0]     cfg_data_i,
  nfcd_in_if.sink                        in_if,
  nfcd_out_if.source                     out_if
);

  import nfcd_pkg::*;

  localparam int unsigned AW    = WORD_ADDR_BITS;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam logic [AW-1:0] SECT_OFS  = AW'(SECTOR_WORDS - 1);
  localparam logic [AW-1:0] BLOCK_OFS = AW'(BLOCK_WORDS - 1);

  // Sequencer of one transaction and of the erase walk.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_PROG  = 4'b1000
  } state_e;

  // Position in the bus command sequence.
  typedef enum logic [8:0] {
    STEP_READ          = 9'b000000001,
    STEP_UNLOCK1       = 9'b000000010,
    STEP_CMD           = 9'b000000100,
    STEP_PROGRAM       = 9'b000001000,
    STEP_ERASE_UNLOCK1 = 9'b000010000,
    STEP_ERASE_UNLOCK2 = 9'b000100000,
    STEP_ERASE_CMD     = 9'b001000000,
    STEP_LOCK          = 9'b010000000,
    STEP_CHIP_LOCK     = 9'b100000000
  } step_e;

  state_e            state_q, state_d;
  step_e             step_q, step_d;
  logic              id_mode_q, id_mode_d;
  logic [TICK_W-1:0] busy_cnt_q, busy_cnt_d;
  logic              poll_q, poll_d;
  logic              blk_lock_q, blk_lock_d;
  logic              chip_lock_q, chip_lock_d;
  logic [AW-1:0]     sweep_addr_q, sweep_addr_d;
  logic [AW-1:0]     sweep_last_q, sweep_last_d;
  logic [AW-1:0]     prog_addr_q, prog_addr_d;
  logic [DATA_W-1:0] prog_data_q, prog_data_d;

  logic [DATA_W-1:0] manuf_q, device_q, prog_ticks_q;
  logic [TICK_W-1:0] erase_ticks_q;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_busy_q, out_busy_d;
  logic              out_refused_q, out_refused_d;

  logic              accept;
  logic              busy;
  logic              locked;
  logic [CMD_W-1:0]  cmd;
  logic [AW-1:0]     addr;
  logic              at_addr1, at_addr2;
  logic              load;
  logic [DATA_W-1:0] res_data;
  logic              res_refused;
  logic              erase_go;
  logic [AW-1:0]     erase_base, erase_last;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // Array storage.
  nfcd_ram #(
    .DATA_W(DATA_W),
    .DEPTH (DEPTH)
  ) u_array (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr),
    .rdata_o(mem_rdata)
  );

  // Handshake and decoded fields.
  assign in_if.ready = (state_q == ST_IDLE) && (!out_valid_q || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign cmd         = in_if.data_word[CMD_W-1:0];
  assign addr        = in_if.word_address;
  assign busy        = (busy_cnt_q != '0);
  assign locked      = blk_lock_q || chip_lock_q;
  assign at_addr1    = (addr == AW'(UNLOCK_ADDR1));
  assign at_addr2    = (addr == AW'(UNLOCK_ADDR2));

  assign out_if.valid     = out_valid_q;
  assign out_if.read_data = out_data_q;
  assign out_if.busy_res  = out_busy_q;
  assign out_if.refused   = out_refused_q;

  // Command decoding, RAM control and result generation.
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    id_mode_d     = id_mode_q;
    busy_cnt_d    = busy_cnt_q;
    poll_d        = poll_q;
    blk_lock_d    = blk_lock_q;
    chip_lock_d   = chip_lock_q;
    sweep_addr_d  = sweep_addr_q;
    sweep_last_d  = sweep_last_q;
    prog_addr_d   = prog_addr_q;
    prog_data_d   = prog_data_q;
    out_valid_d   = out_valid_q && !out_if.ready;
    out_data_d    = out_data_q;
    out_busy_d    = out_busy_q;
    out_refused_d = out_refused_q;
    load          = 1'b0;
    res_data      = '0;
    res_refused   = 1'b0;
    erase_go      = 1'b0;
    erase_base    = '0;
    erase_last    = '1;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = sweep_addr_q;
    mem_wdata     = '1;

    unique case (state_q)
      ST_CLEAR: begin
        // Erase walk: one word per cycle to FFFF.
        mem_we = 1'b1;
        if (sweep_addr_q == sweep_last_q) begin
          state_d = ST_IDLE;
        end else begin
          sweep_addr_d = sweep_addr_q + AW'(1);
        end
      end
      ST_READ: begin
        // Array data arrives in the cycle after the read was issued.
        out_valid_d   = 1'b1;
        out_data_d    = mem_rdata;
        out_busy_d    = busy;
        out_refused_d = 1'b0;
        state_d       = ST_IDLE;
      end
      ST_PROG: begin
        // Programming can only clear bits.
        mem_we    = 1'b1;
        mem_waddr = prog_addr_q;
        mem_wdata = mem_rdata & prog_data_q;
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (kind_e'(in_if.kind))
            KIND_READ: begin
              if (busy) begin
                res_data = {8'h00, poll_q, 7'h00};
              end else if (id_mode_q) begin
                if (addr[AW-1:2] == '0) begin
                  unique case (addr[1:0])
                    ID_MANUF:      res_data = manuf_q;
                    ID_DEVICE:     res_data = device_q;
                    ID_BLOCK_LOCK: res_data = {15'h0000, blk_lock_q};
                    ID_CHIP_LOCK:  res_data = {15'h0000, chip_lock_q};
                    default:       res_data = '0;
                  endcase
                end
              end else begin
                mem_re  = 1'b1;
                load    = 1'b0;
                state_d = ST_READ;
              end
            end
            KIND_WRITE: begin
              if (!busy) begin
                unique case (step_q)
                  STEP_READ: begin
                    if (at_addr1 && cmd == CMD_UNLOCK1) begin
                      step_d = STEP_UNLOCK1;
                    end else begin
                      step_d    = STEP_READ;
                      id_mode_d = 1'b0;
                    end
                  end
                  STEP_UNLOCK1: begin
                    if (at_addr2 && cmd == CMD_UNLOCK2) begin
                      step_d = STEP_CMD;
                    end else begin
                      step_d    = STEP_READ;
                      id_mode_d = 1'b0;
                    end
                  end
                  STEP_CMD: begin
                    if (!at_addr1) begin
                      step_d    = STEP_READ;
                      id_mode_d = 1'b0;
                    end else begin
                      unique case (cmd)
                        CMD_AUTOSELECT: begin
                          step_d    = STEP_READ;
                          id_mode_d = 1'b1;
                        end
                        CMD_PROGRAM:         step_d = STEP_PROGRAM;
                        CMD_ERASE_SETUP:     step_d = STEP_ERASE_UNLOCK1;
                        CMD_LOCK_SETUP:      step_d = STEP_LOCK;
                        CMD_CHIP_LOCK_SETUP: step_d = STEP_CHIP_LOCK;
                        default: begin
                          step_d    = STEP_READ;
                          id_mode_d = 1'b0;
                        end
                      endcase
                    end
                  end
                  STEP_PROGRAM: begin
                    step_d    = STEP_READ;
                    id_mode_d = 1'b0;
                    if (locked) begin
                      res_refused = 1'b1;
                    end else begin
                      mem_re      = 1'b1;
                      prog_addr_d = addr;
                      prog_data_d = in_if.data_word;
                      poll_d      = ~in_if.data_word[7];
                      busy_cnt_d  = TICK_W'(prog_ticks_q);
                      state_d     = ST_PROG;
                    end
                  end
                  STEP_ERASE_UNLOCK1: begin
                    if (at_addr1 && cmd == CMD_UNLOCK1) begin
                      step_d = STEP_ERASE_UNLOCK2;
                    end else begin
                      step_d    = STEP_READ;
                      id_mode_d = 1'b0;
                    end
                  end
                  STEP_ERASE_UNLOCK2: begin
                    if (at_addr2 && cmd == CMD_UNLOCK2) begin
                      step_d = STEP_ERASE_CMD;
                    end else begin
                      step_d    = STEP_READ;
                      id_mode_d = 1'b0;
                    end
                  end
                  STEP_ERASE_CMD: begin
                    step_d    = STEP_READ;
                    id_mode_d = 1'b0;
                    // Chip erase needs the unlock address; sector and block erase align.
                    priority if (cmd == CMD_CHIP_ERASE && at_addr1) begin
                      erase_go = 1'b1;
                    end else if (cmd == CMD_SECTOR_ERASE) begin
                      erase_go   = 1'b1;
                      erase_base = addr & ~SECT_OFS;
                      erase_last = addr | SECT_OFS;
                    end else if (cmd == CMD_BLOCK_ERASE) begin
                      erase_go   = 1'b1;
                      erase_base = addr & ~BLOCK_OFS;
                      erase_last = addr | BLOCK_OFS;
                    end else begin
                      erase_go = 1'b0;
                    end
                    if (erase_go) begin
                      if (locked) begin
                        res_refused = 1'b1;
                      end else begin
                        poll_d       = 1'b0;
                        busy_cnt_d   = erase_ticks_q;
                        sweep_addr_d = erase_base;
                        sweep_last_d = erase_last;
                        state_d      = ST_CLEAR;
                      end
                    end
                  end
                  STEP_LOCK: begin
                    step_d    = STEP_READ;
                    id_mode_d = 1'b0;
                    if (cmd == CMD_UNLOCK_ALL) begin
                      blk_lock_d  = 1'b0;
                      chip_lock_d = 1'b0;
                    end else if (cmd == CMD_LOCK) begin
                      blk_lock_d = 1'b1;
                    end
                  end
                  STEP_CHIP_LOCK: begin
                    step_d    = STEP_READ;
                    id_mode_d = 1'b0;
                    if (cmd == CMD_LOCK) begin
                      chip_lock_d = 1'b1;
                    end
                  end
                  default: begin
                    step_d    = STEP_READ;
                    id_mode_d = 1'b0;
                  end
                endcase
              end
            end
            KIND_TICK: begin
              if (busy) begin
                busy_cnt_d = busy_cnt_q - TICK_W'(1);
              end
            end
            KIND_NONE: begin
              res_data = '0;
            end
            default: begin
              res_data = '0;
            end
          endcase
          if (load) begin
            out_valid_d   = 1'b1;
            out_data_d    = res_data;
            out_busy_d    = (busy_cnt_d != '0);
            out_refused_d = res_refused;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state; reset starts a walk that fills the whole array.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      step_q       <= STEP_READ;
      id_mode_q    <= 1'b0;
      busy_cnt_q   <= '0;
      poll_q       <= 1'b0;
      blk_lock_q   <= 1'b0;
      chip_lock_q  <= 1'b0;
      sweep_addr_q <= '0;
      sweep_last_q <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      id_mode_q    <= id_mode_d;
      busy_cnt_q   <= busy_cnt_d;
      poll_q       <= poll_d;
      blk_lock_q   <= blk_lock_d;
      chip_lock_q  <= chip_lock_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prog_addr_q   <= prog_addr_d;
    prog_data_q   <= prog_data_d;
    out_data_q    <= out_data_d;
    out_busy_q    <= out_busy_d;
    out_refused_q <= out_refused_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manuf_q       <= MANUF_RESET;
      device_q      <= DEVICE_RESET;
      prog_ticks_q  <= PROG_TICKS_RESET;
      erase_ticks_q <= ERASE_TICKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MANUF:       manuf_q       <= cfg_data_i[DATA_W-1:0];
        CFG_DEVICE:      device_q      <= cfg_data_i[DATA_W-1:0];
        CFG_PROG_TICKS:  prog_ticks_q  <= cfg_data_i[DATA_W-1:0];
        CFG_ERASE_TICKS: erase_ticks_q <= cfg_data_i[TICK_W-1:0];
        default: begin
          manuf_q <= manuf_q;
        end
      endcase
    end
  end

  // The erase walk never reads the array.
  `NFCD_ASSERT(a_no_read_in_walk, clk_i, rst_ni, !(state_q == ST_CLEAR && mem_re))

  // Array writes come only from the erase walk or a program write-back.
  `NFCD_ASSERT(a_write_source, clk_i, rst_ni,
               !mem_we || state_q == ST_CLEAR || state_q == ST_PROG)

  // The walk stays inside its range.
  `NFCD_ASSERT(a_walk_range, clk_i, rst_ni,
               state_q != ST_CLEAR || sweep_addr_q <= sweep_last_q)

  // An array read always presents its result in the cycle after the read state.
  `NFCD_ASSERT_NEXT(a_read_result, clk_i, rst_ni, state_q == ST_READ,
                    out_valid_q && state_q == ST_IDLE)

endmodule

`default_nettype wire
